### src/mchw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mchw_pkg
// Shared types and constants of the multi-channel heartbeat watchdog.
// ----------------------------------------------------------------------------
package mchw_pkg;

  // number of watched channels and derived index width
  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // field widths
  localparam int ACTION_W = 2;
  localparam int SLOTF_W  = 4;
  localparam int MS_W     = 32;
  localparam int TIME_W   = 48;
  localparam int EVENT_W  = 3;
  localparam int COUNT_W  = 32;
  localparam int LIMIT_W  = 42;  // 32 bit ms times 1000 fits in 42 bits
  localparam int KILO_W   = 10;

  localparam logic [KILO_W-1:0]  US_PER_MS   = 10'd1000;
  localparam logic [MS_W-1:0]    GRACE_RESET = 32'd60000;

  // actions carried by an input word
  typedef enum logic [ACTION_W-1:0] {
    ACT_REG   = 2'd0,
    ACT_BEAT  = 2'd1,
    ACT_CHECK = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  // per-channel result codes
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_NEW     = 3'd1,
    EV_STILL   = 3'd2,
    EV_RECOVER = 3'd3,
    EV_REBOOT  = 3'd4
  } event_e;

  // one entry of the channel memory
  typedef struct packed {
    logic [MS_W-1:0]   timeout;
    logic [TIME_W-1:0] last_beat;
    logic [TIME_W-1:0] stall_start;
  } entry_t;

  // registered time arithmetic for one channel
  typedef struct packed {
    logic [TIME_W-1:0]  silence;
    logic [TIME_W-1:0]  stall_len;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] grace;
  } calc_t;

endpackage
`default_nettype wire

### src/mchw_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mchw_in_if
// Input word channel: action, slot, timeout and current time.
// ----------------------------------------------------------------------------
interface mchw_in_if;
  logic                               valid;
  logic                               ready;
  logic [mchw_pkg::ACTION_W-1:0]      action;
  logic [mchw_pkg::SLOTF_W-1:0]       slot;
  logic [mchw_pkg::MS_W-1:0]          limit_ms;
  logic [mchw_pkg::TIME_W-1:0]        now_us;

  modport source (output valid, action, slot, limit_ms, now_us, input ready);
  modport sink   (input valid, action, slot, limit_ms, now_us, output ready);
endinterface
`default_nettype wire

### src/mchw_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mchw_out_if
// Result word channel: channel, event, stall flag, stall count, last mark.
// ----------------------------------------------------------------------------
interface mchw_out_if;
  logic                               valid;
  logic                               ready;
  logic [mchw_pkg::SLOTF_W-1:0]       slot_out;
  logic [mchw_pkg::EVENT_W-1:0]       event_res;
  logic                               stalled_flag;
  logic [mchw_pkg::COUNT_W-1:0]       stall_events;
  logic                               last;

  modport source (output valid, slot_out, event_res, stalled_flag, stall_events, last,
                  input ready);
  modport sink   (input valid, slot_out, event_res, stalled_flag, stall_events, last,
                  output ready);
endinterface
`default_nettype wire

### src/mchw_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mchw_cfg_if
// Configuration write channel carrying the reboot grace period in ms.
// ----------------------------------------------------------------------------
interface mchw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mchw_pkg::MS_W-1:0]          data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### src/mchw_calc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mchw_calc
// Time arithmetic stage: silence and stall length clamped at zero, and the
// timeout and grace limits scaled from ms to us, all registered.
// ----------------------------------------------------------------------------
module mchw_calc (
  input  wire logic                          clk_i,
  input  wire logic [mchw_pkg::TIME_W-1:0]   now_i,
  input  wire mchw_pkg::entry_t              entry_i,
  input  wire logic [mchw_pkg::MS_W-1:0]     grace_i,
  output mchw_pkg::calc_t                    calc_o
);

  mchw_pkg::calc_t calc_d;
  mchw_pkg::calc_t calc_q;

  // clamp backwards time to zero, scale limits by a small constant multiply
  always_comb begin
    calc_d.silence   = (now_i >= entry_i.last_beat) ? (now_i - entry_i.last_beat)
                                                     : '0;
    calc_d.stall_len = (now_i >= entry_i.stall_start) ? (now_i - entry_i.stall_start)
                                                       : '0;
    calc_d.limit     = mchw_pkg::LIMIT_W'(entry_i.timeout) *
                       mchw_pkg::LIMIT_W'(mchw_pkg::US_PER_MS);
    calc_d.grace     = mchw_pkg::LIMIT_W'(grace_i) *
                       mchw_pkg::LIMIT_W'(mchw_pkg::US_PER_MS);
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    calc_q <= calc_d;
  end

  assign calc_o = calc_q;

endmodule
`default_nettype wire

### src/multi_channel_heartbeat_watchdog_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_core
// Watchdog over SLOTS channels with register, heartbeat, check and query.
// ----------------------------------------------------------------------------
// Register, heartbeat and query words give one result word, loaded into the
// output register at the edge that accepts them; the next word is taken in
// the following cycle if the output register is free. A check word gives one
// result per channel in index order; per channel S_READ reads the channel
// memory, S_CALC registers the clamped time differences and ms-to-us limits,
// and S_EVAL, which waits while the result side stalls, compares, writes the
// stall start back and emits the result. No word is accepted while a check
// walks. The registered and stall marks sit in flip-flops cleared by reset,
// so no clearing pass runs; the memory is read for every channel of a walk,
// registered or not.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mchw_in_if.sink    in_i,
  mchw_out_if.source out_o,
  mchw_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CALC = 4'b0100,
    S_EVAL = 4'b1000
  } state_e;

  localparam int SW = mchw_pkg::SLOT_W;

  state_e                              state_q, state_d;
  logic [SW-1:0]                       idx_q;
  logic [mchw_pkg::TIME_W-1:0]         now_q;
  logic [mchw_pkg::MS_W-1:0]           grace_q;
  logic [mchw_pkg::SLOTS-1:0]          reg_q;
  logic [mchw_pkg::SLOTS-1:0]          stall_q;
  logic [mchw_pkg::COUNT_W-1:0]        count_q, count_d;

  logic                                out_valid_q;
  logic [mchw_pkg::SLOTF_W-1:0]        out_slot_q;
  mchw_pkg::event_e                    out_ev_q;
  logic                                out_flag_q;
  logic [mchw_pkg::COUNT_W-1:0]        out_count_q;
  logic                                out_last_q;

  mchw_pkg::entry_t                    slot_mem [mchw_pkg::SLOTS];
  mchw_pkg::entry_t                    rd_data_q;
  mchw_pkg::calc_t                     calc;

  logic                                out_free, in_ready, in_fire, in_check;
  logic                                slot_ok, is_reg, is_beat;
  logic [SW-1:0]                       slot_idx;
  logic                                last_idx, eval_go;
  mchw_pkg::event_e                    eval_ev;
  logic                                eval_flag, eval_new, eval_clr;
  logic                                wr_tmo, wr_beat, wr_start;
  logic [SW-1:0]                       wr_addr;
  logic [mchw_pkg::TIME_W-1:0]         wr_start_val;
  logic                                q_flag;

  // handshake
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_ready    = (state_q == S_IDLE) && out_free;
  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;
  assign in_check    = (in_i.action == mchw_pkg::ACT_CHECK);
  assign is_reg      = (in_i.action == mchw_pkg::ACT_REG);
  assign is_beat     = (in_i.action == mchw_pkg::ACT_BEAT);
  assign slot_ok     = ({1'b0, in_i.slot} < 5'(mchw_pkg::SLOTS));
  assign slot_idx    = in_i.slot[SW-1:0];
  assign cfg_i.ready = 1'b1;

  // stall flag of a single-word result
  assign q_flag = slot_ok && !is_reg && stall_q[slot_idx];

  // grace period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grace_q <= mchw_pkg::GRACE_RESET;
    end else if (cfg_i.valid) begin
      grace_q <= cfg_i.data;
    end
  end

  // time arithmetic stage
  mchw_calc u_calc (
    .clk_i   (clk_i),
    .now_i   (now_q),
    .entry_i (rd_data_q),
    .grace_i (grace_q),
    .calc_o  (calc)
  );

  // per-channel decision during a check
  always_comb begin
    eval_ev   = mchw_pkg::EV_NONE;
    eval_flag = 1'b0;
    eval_new  = 1'b0;
    eval_clr  = 1'b0;
    if (reg_q[idx_q]) begin
      if (calc.silence > mchw_pkg::TIME_W'(calc.limit)) begin
        eval_flag = 1'b1;
        if (!stall_q[idx_q]) begin
          eval_ev  = mchw_pkg::EV_NEW;
          eval_new = 1'b1;
        end else if (calc.stall_len > mchw_pkg::TIME_W'(calc.grace)) begin
          eval_ev = mchw_pkg::EV_REBOOT;
        end else begin
          eval_ev = mchw_pkg::EV_STILL;
        end
      end else if (stall_q[idx_q]) begin
        eval_ev  = mchw_pkg::EV_RECOVER;
        eval_clr = 1'b1;
      end
    end
  end

  assign eval_go  = (state_q == S_EVAL) && out_free;
  assign last_idx = (idx_q == SW'(mchw_pkg::SLOTS - 1));
  assign count_d  = (eval_go && eval_new) ? (count_q + 1'b1) : count_q;

  // memory write port: words at accept, stall start during a check
  assign wr_addr      = (state_q == S_EVAL) ? idx_q : slot_idx;
  assign wr_tmo       = in_fire && slot_ok && is_reg;
  assign wr_beat      = in_fire && slot_ok && (is_reg || is_beat);
  assign wr_start     = wr_tmo || (eval_go && (eval_new || eval_clr));
  assign wr_start_val = (state_q == S_EVAL && eval_new) ? now_q : '0;

  // channel memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_tmo) begin
      slot_mem[wr_addr].timeout <= in_i.limit_ms;
    end
    if (wr_beat) begin
      slot_mem[wr_addr].last_beat <= in_i.now_us;
    end
    if (wr_start) begin
      slot_mem[wr_addr].stall_start <= wr_start_val;
    end
    if (state_q == S_READ) begin
      rd_data_q <= slot_mem[idx_q];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && in_check) state_d = S_READ;
      end
      S_READ: state_d = S_CALC;
      S_CALC: state_d = S_EVAL;
      S_EVAL: begin
        if (eval_go) state_d = last_idx ? S_IDLE : S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers and channel marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      reg_q   <= '0;
      stall_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (in_fire && in_check) begin
        idx_q <= '0;
      end else if (eval_go) begin
        idx_q <= SW'(idx_q + 1'b1);
      end
      if (wr_tmo) begin
        reg_q[slot_idx]   <= 1'b1;
        stall_q[slot_idx] <= 1'b0;
      end
      if (eval_go) begin
        stall_q[idx_q] <= eval_flag;
      end
    end
  end

  // check time stamp, held for the whole walk
  always_ff @(posedge clk_i) begin
    if (in_fire && in_check) begin
      now_q <= in_i.now_us;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_fire && !in_check) || eval_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire && !in_check) begin
      out_slot_q  <= in_i.slot;
      out_ev_q    <= mchw_pkg::EV_NONE;
      out_flag_q  <= q_flag;
      out_count_q <= count_q;
      out_last_q  <= 1'b1;
    end else if (eval_go) begin
      out_slot_q  <= mchw_pkg::SLOTF_W'(idx_q);
      out_ev_q    <= eval_ev;
      out_flag_q  <= eval_flag;
      out_count_q <= count_d;
      out_last_q  <= last_idx;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.slot_out     = out_slot_q;
  assign out_o.event_res    = out_ev_q;
  assign out_o.stalled_flag = out_flag_q;
  assign out_o.stall_events = out_count_q;
  assign out_o.last         = out_last_q;

  // a channel can only be stalled while registered
  a_stall_needs_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((stall_q & ~reg_q) == '0))
    else $error("stall mark set on an unregistered channel");

  // the stall count moves only together with a new-stall result word
  a_count_with_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (out_valid_q && out_o.event_res == mchw_pkg::EV_NEW))
    else $error("stall count changed without a new-stall result");

  // the final channel of a walk returns to idle with the last mark set
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_go && last_idx) |=> (state_q == S_IDLE && out_valid_q && out_o.last))
    else $error("check walk did not end with a last word");

endmodule
`default_nettype wire

### test/multi_channel_heartbeat_watchdog_core_tb.sv
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_core_tb
// Self-checking bench for the heartbeat watchdog core. A scoreboard keeps its
// own copy of every channel and the stall count, predicts the result words of
// each accepted input word and compares them, in order, with what the core
// returns. Directed words cover the corner cases, then phases of random
// register/heartbeat/check/query traffic run under several grace settings.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog_core_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_WORDS  = 57;
  localparam int HOLD_CYCLES  = 200;

  // one result word as seen on the output channel
  typedef struct packed {
    logic [mchw_pkg::SLOTF_W-1:0] slot;
    logic [mchw_pkg::EVENT_W-1:0] ev;
    logic                         flag;
    logic [mchw_pkg::COUNT_W-1:0] count;
    logic                         last;
  } wd_word_t;

  // watchdog predictor and ordered store of expected result words
  class watchdog_scoreboard;
    logic                         armed    [mchw_pkg::SLOTS];
    logic                         stalled  [mchw_pkg::SLOTS];
    logic [mchw_pkg::MS_W-1:0]    tmo_ms   [mchw_pkg::SLOTS];
    logic [mchw_pkg::TIME_W-1:0]  beat_us  [mchw_pkg::SLOTS];
    logic [mchw_pkg::TIME_W-1:0]  stall_us [mchw_pkg::SLOTS];
    logic [mchw_pkg::COUNT_W-1:0] stalls_seen;
    logic [mchw_pkg::MS_W-1:0]    grace_ms;
    wd_word_t                     expected_words[$];
    int                           errors;
    int                           words_in;
    int                           words_out;
    int                           n_new;
    int                           n_reboot;
    int                           n_recover;

    function new();
      for (int i = 0; i < mchw_pkg::SLOTS; i++) begin
        armed[i]    = 1'b0;
        stalled[i]  = 1'b0;
        tmo_ms[i]   = '0;
        beat_us[i]  = '0;
        stall_us[i] = '0;
      end
      stalls_seen = '0;
      grace_ms    = mchw_pkg::GRACE_RESET;
      errors      = 0;
      words_in    = 0;
      words_out   = 0;
      n_new       = 0;
      n_reboot    = 0;
      n_recover   = 0;
    endfunction

    function void set_grace(logic [mchw_pkg::MS_W-1:0] value);
      grace_ms = value;
    endfunction

    // one channel of a check walk
    function mchw_pkg::event_e scan_slot(int i, logic [mchw_pkg::TIME_W-1:0] now);
      logic [63:0] silence;
      logic [63:0] limit;
      logic [63:0] span;
      logic [63:0] grace;
      if (!armed[i]) return mchw_pkg::EV_NONE;
      silence = (now >= beat_us[i]) ? 64'(now - beat_us[i]) : 64'd0;
      limit   = 64'(tmo_ms[i]) * 64'd1000;
      if (silence > limit) begin
        if (!stalled[i]) begin
          stalled[i]  = 1'b1;
          stall_us[i] = now;
          stalls_seen = stalls_seen + 1'b1;
          n_new++;
          return mchw_pkg::EV_NEW;
        end
        span  = (now >= stall_us[i]) ? 64'(now - stall_us[i]) : 64'd0;
        grace = 64'(grace_ms) * 64'd1000;
        if (span > grace) begin
          n_reboot++;
          return mchw_pkg::EV_REBOOT;
        end
        return mchw_pkg::EV_STILL;
      end
      if (stalled[i]) begin
        stalled[i]  = 1'b0;
        stall_us[i] = '0;
        n_recover++;
        return mchw_pkg::EV_RECOVER;
      end
      return mchw_pkg::EV_NONE;
    endfunction

    // update the channel copy for an accepted input word, queue its results
    function void predict_word(mchw_pkg::action_e act, logic [mchw_pkg::SLOTF_W-1:0] slot,
                               logic [mchw_pkg::MS_W-1:0] tmo,
                               logic [mchw_pkg::TIME_W-1:0] now);
      wd_word_t w;
      int       idx;
      logic     ok;
      words_in++;
      if (act == mchw_pkg::ACT_CHECK) begin
        for (int i = 0; i < mchw_pkg::SLOTS; i++) begin
          w.ev    = scan_slot(i, now);
          w.slot  = mchw_pkg::SLOTF_W'(i);
          w.flag  = stalled[i];
          w.count = stalls_seen;
          w.last  = (i == mchw_pkg::SLOTS - 1);
          expected_words.push_back(w);
        end
      end else begin
        idx = int'(slot);
        ok  = (idx < mchw_pkg::SLOTS);
        if (ok && act == mchw_pkg::ACT_REG) begin
          tmo_ms[idx]   = tmo;
          beat_us[idx]  = now;
          stall_us[idx] = '0;
          armed[idx]    = 1'b1;
          stalled[idx]  = 1'b0;
        end else if (ok && act == mchw_pkg::ACT_BEAT) begin
          beat_us[idx] = now;
        end
        w.slot  = slot;
        w.ev    = mchw_pkg::EV_NONE;
        w.flag  = ok ? stalled[idx] : 1'b0;
        w.count = stalls_seen;
        w.last  = 1'b1;
        expected_words.push_back(w);
      end
    endfunction

    // compare one accepted result word with the oldest expectation
    function void compare_word(wd_word_t got);
      wd_word_t want;
      words_out++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: slot %0d event %0d flag %0d count %0d last %0d",
                 $time, got.slot, got.ev, got.flag, got.count, got.last);
        return;
      end
      want = expected_words.pop_front();
      if (got.slot !== want.slot || got.ev !== want.ev || got.flag !== want.flag ||
          got.count !== want.count || got.last !== want.last) begin
        errors++;
        $display({"%0t: mismatch expected slot %0d event %0d flag %0d count %0d last %0d",
                  " / actual slot %0d event %0d flag %0d count %0d last %0d"},
                 $time, want.slot, want.ev, want.flag, want.count, want.last,
                 got.slot, got.ev, got.flag, got.count, got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mchw_in_if  in_if ();
  mchw_out_if out_if ();
  mchw_cfg_if cfg_if ();

  multi_channel_heartbeat_watchdog_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  watchdog_scoreboard sb = new();

  bit                          idle_on      = 1'b1;
  bit                          long_hold_go = 1'b0;
  bit                          long_hold_done;
  int                          long_hold_left;
  int                          rx_gap_left;
  int                          cycles;
  logic [mchw_pkg::TIME_W-1:0] t_now;

  // clock
  always #5 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d result words outstanding", $time,
               sb.expected_words.size());
      $display("[multi_channel_heartbeat_watchdog_core] ERROR");
      $finish;
    end
  end

  // result side: check accepted words, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.compare_word('{out_if.slot_out, out_if.event_res, out_if.stalled_flag,
                          out_if.stall_events, out_if.last});
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        long_hold_left = HOLD_CYCLES;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_if.ready <= 1'b0;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rx_gap_left = $urandom_range(1, 4) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // offer one input word and note it at the accepting edge
  task automatic send_word(mchw_pkg::action_e act, logic [mchw_pkg::SLOTF_W-1:0] slot,
                           logic [mchw_pkg::MS_W-1:0] tmo,
                           logic [mchw_pkg::TIME_W-1:0] now);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.slot     <= slot;
    in_if.limit_ms <= tmo;
    in_if.now_us   <= now;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.predict_word(act, slot, tmo, now);
  endtask

  // stop offering and wait for every expected word
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // write the grace period while the core is idle
  task automatic write_grace(logic [mchw_pkg::MS_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    sb.set_grace(value);
  endtask

  // one random word, mostly well formed around a moving time cursor
  task automatic random_item();
    int                           r;
    int                           dt;
    logic [mchw_pkg::SLOTF_W-1:0] s;
    logic [mchw_pkg::MS_W-1:0]    tmo;
    r  = $urandom_range(0, 99);
    dt = $urandom_range(0, 99);
    if (dt < 83) t_now = t_now + $urandom_range(0, 4000);
    else if (dt < 93) t_now = (t_now > 3000) ? t_now - $urandom_range(0, 3000) : t_now;
    else if (dt < 98) t_now = t_now + $urandom_range(0, 200000);
    else t_now = t_now + $urandom_range(0, 70000000);
    s   = ($urandom_range(0, 9) == 0) ?
          mchw_pkg::SLOTF_W'($urandom_range(0, 15)) :
          mchw_pkg::SLOTF_W'($urandom_range(0, mchw_pkg::SLOTS - 1));
    tmo = ($urandom_range(0, 6) == 0) ? mchw_pkg::MS_W'($urandom) :
                                        mchw_pkg::MS_W'($urandom_range(0, 6));
    if (r < 12) send_word(mchw_pkg::ACT_REG, s, tmo, t_now);
    else if (r < 45) send_word(mchw_pkg::ACT_BEAT, s, mchw_pkg::MS_W'($urandom), t_now);
    else if (r < 70) send_word(mchw_pkg::ACT_CHECK, mchw_pkg::SLOTF_W'($urandom_range(0, 15)),
                               mchw_pkg::MS_W'($urandom), t_now);
    else if (r < 86) send_word(mchw_pkg::ACT_QUERY, mchw_pkg::SLOTF_W'($urandom_range(0, 15)),
                               mchw_pkg::MS_W'($urandom), t_now);
    else send_word(mchw_pkg::action_e'($urandom_range(0, 3)),
                   mchw_pkg::SLOTF_W'($urandom_range(0, 15)),
                   mchw_pkg::MS_W'($urandom), mchw_pkg::TIME_W'({$urandom, $urandom}));
  endtask

  // stimulus
  initial begin
    logic [mchw_pkg::MS_W-1:0] grace_plan [5];
    rst_ni           = 1'b0;
    long_hold_done   = 1'b0;
    long_hold_left   = 0;
    rx_gap_left      = 0;
    t_now            = '0;
    in_if.valid      = 1'b0;
    in_if.action     = mchw_pkg::ACT_REG;
    in_if.slot       = '0;
    in_if.limit_ms   = '0;
    in_if.now_us     = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    grace_plan[0]    = 32'hFFFF_FFFF;
    grace_plan[1]    = 32'd3;
    grace_plan[2]    = 32'd0;
    grace_plan[3]    = mchw_pkg::GRACE_RESET;
    grace_plan[4]    = mchw_pkg::MS_W'($urandom_range(1, 20));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty core, arming, out-of-range slots, extremes of time
    send_word(mchw_pkg::ACT_QUERY, 4'd0, 32'd0, 48'd0);
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd0);
    send_word(mchw_pkg::ACT_REG, 4'd0, 32'd0, 48'd100);
    send_word(mchw_pkg::ACT_REG, 4'd1, 32'hFFFF_FFFF, 48'd0);
    send_word(mchw_pkg::ACT_REG, 4'd7, 32'd5, 48'd1000);
    send_word(mchw_pkg::ACT_REG, 4'd8, 32'd1, 48'd5);
    send_word(mchw_pkg::ACT_BEAT, 4'd15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_word(mchw_pkg::ACT_BEAT, 4'd3, 32'd0, 48'd500);
    // zero limit is not exceeded at zero silence, one microsecond later it is
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd100);
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd101);
    send_word(mchw_pkg::ACT_QUERY, 4'd0, 32'd0, 48'd101);
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd6001);
    // heartbeat leaves the mark, the next check recovers
    send_word(mchw_pkg::ACT_BEAT, 4'd0, 32'd0, 48'd7000);
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd7000);
    // far future: long stall past grace, widest limit exceeded
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
    // time going backwards clamps silence to zero
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd50);
    // time before the stall start clamps the stall length
    send_word(mchw_pkg::ACT_REG, 4'd0, 32'd0, 48'd10);
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd2000);
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd1500);
    send_word(mchw_pkg::ACT_QUERY, 4'd9, 32'd0, 48'd1500);
    // register clears a stall mark
    send_word(mchw_pkg::ACT_REG, 4'd0, 32'd3, 48'd1500);
    send_word(mchw_pkg::ACT_QUERY, 4'd0, 32'd0, 48'd1500);
    send_word(mchw_pkg::ACT_QUERY, 4'd15, 32'd0, 48'd1500);
    // zero grace: reboot one microsecond into a stall
    write_grace(32'd0);
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd4501);
    send_word(mchw_pkg::ACT_CHECK, 4'd0, 32'd0, 48'd4502);

    // random phases, one grace setting each
    t_now = 48'd5000;
    for (int p = 0; p < 5; p++) begin
      write_grace(grace_plan[p]);
      if (p == 1) long_hold_go <= 1'b1;
      if (p == 4) idle_on <= 1'b0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 2 && k == PHASE_WORDS / 2) wait_drained();
        random_item();
      end
    end

    // drain and let any stray word show up
    wait_drained();
    repeat (30) @(posedge clk_i);

    $display("run covered %0d input words and %0d result words over six grace writes",
             sb.words_in, sb.words_out);
    $display("stall events seen: %0d new, %0d reboot requests, %0d recoveries",
             sb.n_new, sb.n_reboot, sb.n_recover);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("[multi_channel_heartbeat_watchdog_core] OK");
    end else begin
      if (sb.expected_words.size() != 0)
        $display("%0t: %0d expected result words never arrived", $time,
                 sb.expected_words.size());
      $display("[multi_channel_heartbeat_watchdog_core] ERROR");
    end
    $finish;
  end

endmodule
